>>> src/nfdp_pkg.sv
// shared types, constants and date helper functions for the nmea fix and date parser
// no dependencies; used by nfdp_date_conv and nmea_fix_and_date_parser_core
package nfdp_pkg;

    localparam int unsigned MAX_LINE = 80;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned HDR_LEN  = 6;
    localparam int unsigned DATE_LEN = 6;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] LINE_FEED   = 8'h0A;

    localparam logic [3:0] FIX_COMMA   = 4'd6;
    localparam logic [3:0] DATE_COMMA  = 4'd9;
    localparam logic [3:0] COMMA_MAX   = 4'd15;

    localparam logic [11:0] BASE_YEAR     = 12'd2000;
    localparam logic [15:0] DAYS_TO_2000  = 16'd10957;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;

    typedef enum logic {
        KIND_GGA = 1'b0,
        KIND_RMC = 1'b1
    } t_kind;

    typedef logic [DATE_LEN-1:0][7:0] t_date_chars;

    typedef struct packed {
        logic        valid;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [15:0] days;
    } t_date;

    function automatic logic [7:0] hdr_gga_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd2:                         n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:           n = 5'd31;
            default:                      n = 5'd0;
        endcase
        return n;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // days from 1970 to the first of year 2000 + yy, valid through 2099
    function automatic logic [15:0] year_days(input logic [6:0] yy);
        logic [15:0] leaps;
        leaps = 16'((8'(yy) + 8'd3) >> 2);
        return DAYS_TO_2000 + 16'(DAYS_PER_YEAR * 16'(yy)) + leaps;
    endfunction

endpackage

>>> src/nfdp_date_conv.sv
// date field decoder: six captured characters to day, month, year and epoch day count
// depends on nfdp_pkg
module nfdp_date_conv (
    input  nfdp_pkg::t_date_chars i_chars,
    input  logic                  i_full,
    output nfdp_pkg::t_date       o_date
);

    logic        digits_ok;
    logic [6:0]  day;
    logic [6:0]  mon;
    logic [6:0]  yy;
    logic        leap;
    logic [4:0]  lim;
    logic        mon_ok;
    logic        day_ok;
    logic        valid;
    logic [15:0] days;

    always_comb begin
        digits_ok = 1'b1;
        for (int i = 0; i < nfdp_pkg::DATE_LEN; i++) begin
            if (i_chars[i] < nfdp_pkg::CHAR_ZERO || i_chars[i] > nfdp_pkg::CHAR_NINE) begin
                digits_ok = 1'b0;
            end
        end
    end

    assign day  = 7'(7'(i_chars[0][3:0]) * 7'd10) + 7'(i_chars[1][3:0]);
    assign mon  = 7'(7'(i_chars[2][3:0]) * 7'd10) + 7'(i_chars[3][3:0]);
    assign yy   = 7'(7'(i_chars[4][3:0]) * 7'd10) + 7'(i_chars[5][3:0]);
    assign leap = (yy[1:0] == 2'd0);

    assign mon_ok = (mon >= 7'd1) && (mon <= 7'd12);
    assign lim    = nfdp_pkg::month_len(mon[3:0], leap);
    assign day_ok = (day >= 7'd1) && (day <= 7'(lim));
    assign valid  = i_full && digits_ok && mon_ok && day_ok;

    assign days = nfdp_pkg::year_days(yy)
                + 16'(nfdp_pkg::month_start(mon[3:0]))
                + 16'(leap && (mon > 7'd2))
                + 16'(day) - 16'd1;

    always_comb begin
        o_date = '0;
        if (valid) begin
            o_date.valid = 1'b1;
            o_date.day   = day[4:0];
            o_date.month = mon[3:0];
            o_date.year  = nfdp_pkg::BASE_YEAR + 12'(yy);
            o_date.days  = days;
        end
    end

endmodule

>>> src/nmea_fix_and_date_parser_core.sv
// nmea gga / rmc sentence parser top level: byte parser, date stage and output register
// depends on nfdp_pkg and nfdp_date_conv
//
// usage:
// - s_axis carries one received serial character per transaction in tdata[7:0]
// - a '$' starts a line; a line feed ends it and, for a complete $GPGGA or
//   $GPRMC header, yields one result on m_axis; other bytes yield nothing
// - m_axis tuser holds the sentence kind (0 gga, 1 rmc); tdata holds the
//   fix flag, date valid flag, day, month, year and days since 1 jan 1970
// - a line that reaches 80 characters, or that did not start with '$',
//   gives no result
// - one character is accepted every cycle while s_axis_tready is high; the parser
//   state updates in the accepting cycle, the date is decoded in a second register stage
// - a result moves from the parser into the date stage register, then through the
//   date decoder into the output register that drives m_axis
// - when the receiver stalls, the result waits in the output register and
//   one more result can wait in the date stage; s_axis_tready drops only
//   when both are occupied and the output is not taken
// - reset (i_rst_n low, synchronous) drops any partial line and any
//   pending result
module nmea_fix_and_date_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] fix_locked, [1] date_valid, [6:2] day_of_month,
                                        // [10:7] month_number, [22:11] full_year,
                                        // [38:23] days_since_epoch, [39] zero
    output logic        m_axis_tuser    // [0] sentence_kind
);

    localparam logic [nfdp_pkg::POS_W-1:0] POS_MAX = nfdp_pkg::POS_W'(nfdp_pkg::MAX_LINE);
    localparam logic [nfdp_pkg::POS_W-1:0] POS_HDR = nfdp_pkg::POS_W'(nfdp_pkg::HDR_LEN);
    localparam logic [2:0] DATE_CNT_FULL = 3'(nfdp_pkg::DATE_LEN);

    // parser state
    logic [nfdp_pkg::POS_W-1:0] r_line_pos, n_line_pos;
    logic                       r_line_active, n_line_active;
    logic                       r_gga_match, n_gga_match;
    logic                       r_rmc_match, n_rmc_match;
    logic [3:0]                 r_comma_cnt, n_comma_cnt;
    logic [7:0]                 r_fix_char, n_fix_char;
    logic                       r_fix_captured, n_fix_captured;
    nfdp_pkg::t_date_chars      r_date_chars, n_date_chars;
    logic [2:0]                 r_date_cnt, n_date_cnt;

    // date stage
    logic                  r_b_valid;
    nfdp_pkg::t_kind       r_b_kind;
    logic                  r_b_fix;
    logic                  r_b_full;
    nfdp_pkg::t_date_chars r_b_chars;

    // output register
    logic            r_out_valid;
    nfdp_pkg::t_kind r_out_kind;
    logic            r_out_fix;
    nfdp_pkg::t_date r_out_date;

    logic            s_accept;
    logic            out_free;
    logic            b_free;
    logic            emit;
    nfdp_pkg::t_kind emit_kind;
    logic            emit_fix;
    nfdp_pkg::t_date date;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign b_free        = !r_b_valid || out_free;
    assign s_axis_tready = b_free;
    assign s_accept      = s_axis_tvalid && b_free;

    always_comb begin
        n_line_pos     = r_line_pos;
        n_line_active  = r_line_active;
        n_gga_match    = r_gga_match;
        n_rmc_match    = r_rmc_match;
        n_comma_cnt    = r_comma_cnt;
        n_fix_char     = r_fix_char;
        n_fix_captured = r_fix_captured;
        n_date_chars   = r_date_chars;
        n_date_cnt     = r_date_cnt;
        emit           = 1'b0;
        emit_kind      = nfdp_pkg::KIND_GGA;
        emit_fix       = 1'b0;
        if (s_accept) begin
            if (s_axis_tdata == nfdp_pkg::CHAR_DOLLAR) begin
                n_line_active  = 1'b1;
                n_line_pos     = nfdp_pkg::POS_W'(1);
                n_gga_match    = 1'b1;
                n_rmc_match    = 1'b1;
                n_comma_cnt    = '0;
                n_fix_char     = '0;
                n_fix_captured = 1'b0;
                n_date_cnt     = '0;
            end else if (r_line_active) begin
                if (r_line_pos >= POS_MAX) begin
                    n_line_active = 1'b0;
                end else begin
                    n_line_pos = r_line_pos + nfdp_pkg::POS_W'(1);
                    if (s_axis_tdata == nfdp_pkg::LINE_FEED) begin
                        n_line_active = 1'b0;
                        if (r_line_pos >= POS_HDR) begin
                            if (r_gga_match) begin
                                emit      = 1'b1;
                                emit_kind = nfdp_pkg::KIND_GGA;
                                emit_fix  = !(r_fix_captured &&
                                              r_fix_char == nfdp_pkg::CHAR_ZERO);
                            end else if (r_rmc_match) begin
                                emit      = 1'b1;
                                emit_kind = nfdp_pkg::KIND_RMC;
                            end
                        end
                    end else begin
                        if (r_line_pos < POS_HDR) begin
                            if (s_axis_tdata != nfdp_pkg::hdr_gga_char(r_line_pos[2:0])) begin
                                n_gga_match = 1'b0;
                            end
                            if (s_axis_tdata != nfdp_pkg::hdr_rmc_char(r_line_pos[2:0])) begin
                                n_rmc_match = 1'b0;
                            end
                        end
                        if (r_comma_cnt == nfdp_pkg::FIX_COMMA && !r_fix_captured) begin
                            n_fix_char     = s_axis_tdata;
                            n_fix_captured = 1'b1;
                        end
                        if (r_comma_cnt == nfdp_pkg::DATE_COMMA && r_date_cnt < DATE_CNT_FULL) begin
                            n_date_chars[r_date_cnt] = s_axis_tdata;
                            n_date_cnt               = r_date_cnt + 3'd1;
                        end
                        if (s_axis_tdata == nfdp_pkg::CHAR_COMMA &&
                            r_comma_cnt < nfdp_pkg::COMMA_MAX) begin
                            n_comma_cnt = r_comma_cnt + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos     <= '0;
            r_line_active  <= 1'b0;
            r_gga_match    <= 1'b0;
            r_rmc_match    <= 1'b0;
            r_comma_cnt    <= '0;
            r_fix_captured <= 1'b0;
            r_date_cnt     <= '0;
        end else begin
            r_line_pos     <= n_line_pos;
            r_line_active  <= n_line_active;
            r_gga_match    <= n_gga_match;
            r_rmc_match    <= n_rmc_match;
            r_comma_cnt    <= n_comma_cnt;
            r_fix_captured <= n_fix_captured;
            r_date_cnt     <= n_date_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fix_char   <= n_fix_char;
        r_date_chars <= n_date_chars;
    end

    // date stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (emit) begin
            r_b_valid <= 1'b1;
        end else if (out_free) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_b_kind  <= emit_kind;
            r_b_fix   <= emit_fix;
            r_b_full  <= (emit_kind == nfdp_pkg::KIND_RMC) && (r_date_cnt == DATE_CNT_FULL);
            r_b_chars <= r_date_chars;
        end
    end

    nfdp_date_conv u_date_conv (
        .i_chars (r_b_chars),
        .i_full  (r_b_full),
        .o_date  (date)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_b_valid) begin
            r_out_kind <= r_b_kind;
            r_out_fix  <= r_b_fix;
            r_out_date <= date;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {1'b0, r_out_date.days, r_out_date.year, r_out_date.month,
                            r_out_date.day, r_out_date.valid, r_out_fix};

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_pos <= POS_MAX)
        else $error("line position beyond maximum");

    a_headers_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_active && r_line_pos >= 7'd4) |-> !(r_gga_match && r_rmc_match))
        else $error("both headers still match");

    a_gga_no_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == nfdp_pkg::KIND_GGA) |-> (m_axis_tdata[38:1] == '0))
        else $error("gga result carries date fields");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |->
        (m_axis_tdata[6:2] != 5'd0 && m_axis_tdata[10:7] != 4'd0 &&
         m_axis_tdata[10:7] <= 4'd12 && m_axis_tuser == nfdp_pkg::KIND_RMC))
        else $error("valid date out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !out_free) |=> (r_b_valid && $stable(r_b_chars)))
        else $error("date stage lost while output stalled");

endmodule

>>> test/nfdp_checker.sv
// checker for the nmea fix and date parser: watches both stream channels,
// predicts each sentence result from the accepted characters and compares
// depends on nfdp_pkg
`timescale 1ns / 100ps

module nfdp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    import nfdp_pkg::*;

    localparam logic [47:0] GGA_HEADER = "$GPGGA";
    localparam logic [47:0] RMC_HEADER = "$GPRMC";
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        t_kind       kind;
        logic        fix;
        logic        valid;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [15:0] days;
    } t_sentence_result;

    t_sentence_result  sentence_results_q [$];

    logic [6:0]       line_pos;
    logic             in_line;
    logic             gga_ok;
    logic             rmc_ok;
    logic [3:0]       comma_cnt;
    logic [7:0]       fix_char;
    logic             fix_seen;
    logic [5:0][7:0]  date_buf;
    logic [2:0]       date_len;

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        return MONTH_DAYS[m-1] + ((m == 2 && leap_year(y)) ? 1 : 0);
    endfunction

    function automatic t_sentence_result rmc_date(input logic [2:0] n,
                                                  input logic [5:0][7:0] c);
        t_sentence_result r;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned total;
        r = '0;
        r.kind = KIND_RMC;
        if (n != 3'(DATE_LEN))
            return r;
        for (int i = 0; i < 6; i++)
            if (c[i] < CHAR_ZERO || c[i] > CHAR_NINE)
                return r;
        d = 10 * (c[0] - CHAR_ZERO) + (c[1] - CHAR_ZERO);
        m = 10 * (c[2] - CHAR_ZERO) + (c[3] - CHAR_ZERO);
        y = 2000 + 10 * (c[4] - CHAR_ZERO) + (c[5] - CHAR_ZERO);
        if (m < 1 || m > 12)
            return r;
        if (d < 1 || d > month_length(m, y))
            return r;
        total = d - 1;
        for (int unsigned i = 1; i < m; i++)
            total += month_length(i, y);
        for (int unsigned yr = 1970; yr < y; yr++)
            total += leap_year(yr) ? 366 : 365;
        r.valid = 1'b1;
        r.day   = 5'(d);
        r.month = 4'(m);
        r.year  = 12'(y);
        r.days  = 16'(total);
        return r;
    endfunction

    task automatic take_char(input logic [7:0] b);
        logic [6:0] p;
        t_sentence_result r;
        if (b == CHAR_DOLLAR) begin
            in_line   = 1'b1;
            line_pos  = 7'd1;
            gga_ok    = 1'b1;
            rmc_ok    = 1'b1;
            comma_cnt = '0;
            fix_char  = '0;
            fix_seen  = 1'b0;
            date_len  = '0;
        end else if (in_line) begin
            p = line_pos;
            if (p >= MAX_LINE) begin
                in_line = 1'b0;
            end else begin
                line_pos = p + 7'd1;
                if (b == LINE_FEED) begin
                    in_line = 1'b0;
                    if (p >= HDR_LEN) begin
                        if (gga_ok) begin
                            r = '0;
                            r.kind = KIND_GGA;
                            r.fix = !(fix_seen && fix_char == CHAR_ZERO);
                            sentence_results_q.push_back(r);
                        end else if (rmc_ok) begin
                            sentence_results_q.push_back(rmc_date(date_len, date_buf));
                        end
                    end
                end else begin
                    if (p < HDR_LEN) begin
                        if (b != GGA_HEADER[47 - 8*p -: 8])
                            gga_ok = 1'b0;
                        if (b != RMC_HEADER[47 - 8*p -: 8])
                            rmc_ok = 1'b0;
                    end
                    if (comma_cnt == FIX_COMMA && !fix_seen) begin
                        fix_char = b;
                        fix_seen = 1'b1;
                    end
                    if (comma_cnt == DATE_COMMA && date_len < 3'(DATE_LEN)) begin
                        date_buf[date_len] = b;
                        date_len++;
                    end
                    if (b == CHAR_COMMA && comma_cnt < COMMA_MAX)
                        comma_cnt++;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_result(input logic [39:0] data, input logic kind);
        t_sentence_result want;
        if (sentence_results_q.size() == 0) begin
            report_mismatch($sformatf("result with none expected, kind %0d data %h",
                                      kind, data));
        end else begin
            want = sentence_results_q.pop_front();
            check_field("sentence_kind", 16'(kind), 16'(want.kind));
            check_field("fix_locked", 16'(data[0]), 16'(want.fix));
            check_field("date_valid", 16'(data[1]), 16'(want.valid));
            check_field("day_of_month", 16'(data[6:2]), 16'(want.day));
            check_field("month_number", 16'(data[10:7]), 16'(want.month));
            check_field("full_year", 16'(data[22:11]), 16'(want.year));
            check_field("days_since_epoch", data[38:23], want.days);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_pos     = '0;
            in_line      = 1'b0;
            gga_ok       = 1'b0;
            rmc_ok       = 1'b0;
            comma_cnt    = '0;
            fix_char     = '0;
            fix_seen     = 1'b0;
            date_buf     = '0;
            date_len     = '0;
            o_fail_count = 0;
            sentence_results_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                take_char(i_s_tdata);
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata, i_m_tuser);
        end
        o_pending = sentence_results_q.size();
    end

endmodule

>>> test/tb_top.sv
// testbench top for nmea_fix_and_date_parser_core: feeds directed and random
// nmea lines with random idling and back-pressure, gives the verdict
// depends on nfdp_pkg, nmea_fix_and_date_parser_core and nfdp_checker
`timescale 1ns / 100ps

module tb_top;
    import nfdp_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_CHARS   = 120;
    localparam int DRAIN_CYCLES  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int results_pending;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_seq = 0;
    int chars_sent = 0;
    int idle_tab [4] = '{0, 88, 0, 15};
    int stall_tab [4] = '{0, 0, 88, 15};

    logic [7:0] line_bytes [$];

    nmea_fix_and_date_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    nfdp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("nmea_fix_and_date_parser_core test failed");
        $finish;
    end

    // receiver side: random stalls plus a long hold-off on request
    initial begin
        int seen_hold;
        int hold_left;
        seen_hold = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_hold) begin
                seen_hold = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_char(line_bytes[i]);
        line_bytes.delete();
    endtask

    task automatic push_char(input logic [7:0] b);
        line_bytes.push_back(b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic push_num2(input int n);
        push_char(CHAR_ZERO + 8'(n / 10));
        push_char(CHAR_ZERO + 8'(n % 10));
    endtask

    // any byte that cannot start, split or end a sentence
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: c = CHAR_ZERO + 8'($urandom_range(9));
            6, 7:             c = "A" + 8'($urandom_range(25));
            8:                c = ".";
            default: begin
                do c = 8'($urandom_range(255));
                while (c == CHAR_DOLLAR || c == LINE_FEED || c == CHAR_COMMA);
            end
        endcase
        return c;
    endfunction

    task automatic push_text(input int max_len);
        repeat ($urandom_range(max_len))
            push_char(text_char());
    endtask

    task automatic build_gga();
        int nf;
        nf = ($urandom_range(9) < 8) ? 14 : $urandom_range(14);
        push_str("$GPGGA");
        for (int f = 1; f <= nf; f++) begin
            push_char(CHAR_COMMA);
            if (f == 6) begin
                case ($urandom_range(4))
                    0: push_char(CHAR_ZERO);
                    1: push_char("1");
                    2: push_char(CHAR_ZERO + 8'($urandom_range(2, 8)));
                    3: push_text(3);
                    default: ;
                endcase
            end else begin
                push_text(3);
            end
        end
        if ($urandom_range(1))
            push_str("*4F");
        push_char(LINE_FEED);
    endtask

    task automatic build_rmc();
        int nf;
        int sel;
        nf = ($urandom_range(9) < 8) ? 12 : $urandom_range(12);
        sel = $urandom_range(9);
        push_str("$GPRMC");
        for (int f = 1; f <= nf; f++) begin
            push_char(CHAR_COMMA);
            if (f == 9) begin
                case (sel)
                    0, 1, 2, 3, 4: begin
                        push_num2($urandom_range(1, 28));
                        push_num2($urandom_range(1, 12));
                        push_num2($urandom_range(99));
                    end
                    5, 6: begin
                        push_num2($urandom_range(29, 31));
                        push_num2($urandom_range(1, 12));
                        push_num2($urandom_range(99));
                    end
                    7: begin
                        push_num2($urandom_range(31));
                        push_num2($urandom_range(13));
                        push_num2($urandom_range(99));
                    end
                    8: repeat ($urandom_range(5))
                        push_char(CHAR_ZERO + 8'($urandom_range(9)));
                    default: repeat (6)
                        push_char(text_char());
                endcase
            end else begin
                push_text(3);
            end
        end
        push_char(LINE_FEED);
    endtask

    task automatic build_random_line();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            build_gga();
        end else if (sel < 80) begin
            build_rmc();
        end else if (sel < 90) begin
            if ($urandom_range(1))
                build_gga();
            else
                build_rmc();
            case ($urandom_range(3))
                0: line_bytes[$urandom_range(1, 5)] = text_char();
                1: begin
                    line_bytes = line_bytes[0:$urandom_range(5)];
                    push_char(LINE_FEED);
                end
                2: begin
                    line_bytes = line_bytes[0:5];
                    repeat ($urandom_range(70, 85))
                        push_char(text_char());
                    push_char(LINE_FEED);
                end
                default: void'(line_bytes.pop_front());
            endcase
        end else begin
            repeat ($urandom_range(1, 20))
                push_char(8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines
        push_char(8'h00);
        push_char(8'hFF);
        push_str("abc\n");
        push_str("$GPGGA,1,2,3,4,5,0,x\n");
        push_str("$GPGGA,,,,,,1\n");
        push_str("$GPGGA,,,,,,\n");
        push_str("$GPGGA\n");
        push_str("\n");
        push_str("$GPG\n");
        push_str("$GPXYZ,,,\n");
        push_str("$GPRMC,,,,,,,,,010100\n");
        push_str("$GPRMC,,,,,,,,,311299,\n");
        push_str("$GPRMC,,,,,,,,,290200\n");
        push_str("$GPRMC,,,,,,,,,290201\n");
        push_str("$GPRMC,,,,,,,,,310499\n");
        push_str("$GPRMC,,,,,,,,,011300\n");
        push_str("$GPRMC,,,,,,,,,000100\n");
        push_str("$GPRMC,,,,,,,,,0101\n");
        push_str("$GPRMC,,,,,,,,,01,100\n");
        push_str("$GPRMC,,,,,,,,,0a0100\n");
        push_str("$GPGGA,,$GPRMC,,,,,,,,,150724\n");
        push_str("$GPGGA");
        repeat (73) push_char("x");
        push_char(LINE_FEED);
        push_str("$GPGGA");
        repeat (74) push_char("x");
        push_str("\n\n");
        send_line();

        // random lines under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = idle_tab[ph];
            sink_stall_pct = stall_tab[ph];
            chars_sent     = 0;
            while (chars_sent < PHASE_CHARS) begin
                build_random_line();
                send_line();
            end
        end

        // long receiver hold-off while short sentences keep coming
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_seq++;
        repeat (12) begin
            push_str("$GPGGA,,,,,,");
            push_char(CHAR_ZERO + 8'($urandom_range(1)));
            push_char(LINE_FEED);
            send_line();
        end
        s_axis_tvalid <= 1'b0;

        @(negedge i_clk);
        while (results_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0)
            $display("nmea_fix_and_date_parser_core test passed");
        else
            $display("nmea_fix_and_date_parser_core test failed");
        $finish;
    end

endmodule
